// ===== rtl/core/ffsa_pkg.sv =====
package ffsa_pkg;
   localparam int MaxSegments = 16;
   localparam int IdxBits = $clog2(MaxSegments);
   localparam int CntBits = IdxBits + 1;
   localparam int AddrBits = 16;
   localparam int LenBits = AddrBits + 1;
   localparam int MaxPriority = 4;

   localparam logic [2:0] ST_ALLOC   = 3'd0;
   localparam logic [2:0] ST_FREED   = 3'd1;
   localparam logic [2:0] ST_NOFIT   = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_ZERO    = 3'd4;
   localparam logic [2:0] ST_NOSEG   = 3'd5;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic init;        // reload table from memory size
      logic load;        // capture request
      logic scan;        // compare entry at scan index
      logic scan_rst;    // scan index to zero
      logic split;       // write split hole at idx+1, owner at idx
      logic alloc_exact; // write owner at idx
      logic shift_up;    // copy k-1 to k, k decrements
      logic shift_dn;    // copy k+1 to k, k increments
      logic set_k_top;   // k = count
      logic free_mark;   // mark idx hole, latch result
      logic merge_next;  // merge idx+1 into idx, remove index idx+1
      logic merge_prev;  // merge idx into idx-1, remove index idx
      logic cnt_dec;
      logic cnt_inc;
      logic pid_inc;
      logic [2:0] res_status;
      logic res_set;
   } ffsa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op;
      logic size_zero;
      logic hit;         // current entry matches
      logic scan_end;    // scan index at count
      logic exact;
      logic full;
      logic next_hole;
      logic prev_hole;
      logic k_done_up;   // k <= idx+1
      logic k_done_dn;   // k+1 >= count
   } ffsa_sts_type;
endpackage

// ===== rtl/core/ffsa_ctrl.sv =====
module ffsa_ctrl
   import ffsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         csr_valid,
   output logic         csr_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ffsa_sts_type sts,
   output ffsa_cmd_type cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_FOUND, S_SHIFT_UP, S_FILL,
      S_FREE_FOUND, S_MERGE_N, S_SHIFT_DN, S_MERGE_P, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      prev_pend_ff, prev_pend_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      prev_pend_in = prev_pend_ff;
      cmd = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ready && csr_valid) cmd.init = 1'b1;
            else if (req_ready && req_valid) begin
               cmd.load = 1'b1;
               cmd.scan_rst = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.op == OP_ALLOC && sts.size_zero) begin
               cmd.res_set = 1'b1;
               cmd.res_status = ST_ZERO;
               state_in = S_DONE;
            end else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_end) begin
               cmd.res_set = 1'b1;
               cmd.res_status = (sts.op == OP_ALLOC) ? ST_NOFIT : ST_NOSEG;
               state_in = S_DONE;
            end else if (sts.hit) begin
               state_in = (sts.op == OP_ALLOC) ? S_FOUND : S_FREE_FOUND;
            end else cmd.scan = 1'b1;
         end
         S_FOUND: begin
            if (sts.exact) begin
               cmd.alloc_exact = 1'b1;
               cmd.pid_inc = 1'b1;
               state_in = S_DONE;
            end else if (sts.full) begin
               cmd.res_set = 1'b1;
               cmd.res_status = ST_FULL;
               state_in = S_DONE;
            end else begin
               cmd.set_k_top = 1'b1;
               state_in = S_SHIFT_UP;
            end
         end
         S_SHIFT_UP: begin
            if (sts.k_done_up) state_in = S_FILL;
            else cmd.shift_up = 1'b1;
         end
         S_FILL: begin
            cmd.split = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.pid_inc = 1'b1;
            state_in = S_DONE;
         end
         S_FREE_FOUND: begin
            cmd.free_mark = 1'b1;
            prev_pend_in = 1'b1;
            state_in = S_MERGE_N;
         end
         S_MERGE_N: begin
            if (sts.next_hole) begin
               cmd.merge_next = 1'b1;
               state_in = S_SHIFT_DN;
            end else if (sts.prev_hole) begin
               cmd.merge_prev = 1'b1;
               prev_pend_in = 1'b0;
               state_in = S_SHIFT_DN;
            end else state_in = S_DONE;
         end
         S_SHIFT_DN: begin
            if (sts.k_done_dn) begin
               cmd.cnt_dec = 1'b1;
               state_in = S_MERGE_P;
            end else cmd.shift_dn = 1'b1;
         end
         S_MERGE_P: begin
            if (prev_pend_ff && sts.prev_hole) begin
               cmd.merge_prev = 1'b1;
               prev_pend_in = 1'b0;
               state_in = S_SHIFT_DN;
            end else state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_pend_ff <= prev_pend_in;
      end
   end
endmodule

// ===== rtl/core/ffsa_dp.sv =====
module ffsa_dp
   import ffsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ffsa_cmd_type         cmd,
   output ffsa_sts_type         sts,
   input  logic [LenBits-1:0]   csr_data,
   input  logic                 req_op,
   input  logic signed [7:0]    req_priority_req,
   input  logic [LenBits-1:0]   req_size,
   input  logic [AddrBits-1:0]  req_free_start,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_pid,
   output logic [15:0]          rsp_seg_first,
   output logic [15:0]          rsp_seg_last,
   output logic [2:0]           rsp_granted_priority
);
   logic [AddrBits-1:0] base_ff [MaxSegments];
   logic [LenBits-1:0]  len_ff  [MaxSegments];
   logic [15:0]         own_ff  [MaxSegments];
   logic [2:0]          prio_ff [MaxSegments];
   logic [MaxSegments-1:0] hole_ff;

   logic [CntBits-1:0]  cnt_ff, idx_ff, k_ff;
   logic [15:0]         pid_ff;
   logic [LenBits-1:0]  msize_in;
   logic                op_ff;
   logic [2:0]          gp_ff, gp_in;
   logic [LenBits-1:0]  size_ff;
   logic [AddrBits-1:0] start_ff;

   logic [IdxBits-1:0]  ii, ip, in1, kk, kp, kn;
   logic [AddrBits-1:0] hb;
   logic [LenBits-1:0]  hl;

   assign ii  = idx_ff[IdxBits-1:0];
   assign ip  = ii - 1'b1;
   assign in1 = ii + 1'b1;
   assign kk  = k_ff[IdxBits-1:0];
   assign kp  = kk - 1'b1;
   assign kn  = kk + 1'b1;
   assign hb  = base_ff[ii];
   assign hl  = len_ff[ii];

   always_comb begin
      if (req_priority_req[7]) gp_in = 3'd0;
      else if (req_priority_req > 8'sd4) gp_in = 3'(MaxPriority);
      else gp_in = req_priority_req[2:0];
      if (csr_data == '0) msize_in = LenBits'(1);
      else if (csr_data > (LenBits'(1) << AddrBits)) msize_in = LenBits'(1) << AddrBits;
      else msize_in = csr_data;
   end

   assign sts.op        = op_ff;
   assign sts.size_zero = (size_ff == '0);
   assign sts.scan_end  = (idx_ff >= cnt_ff);
   assign sts.hit       = (op_ff == OP_ALLOC) ? (hole_ff[ii] && hl >= size_ff)
                                              : (!hole_ff[ii] && hb == start_ff);
   assign sts.exact     = (hl == size_ff);
   assign sts.full      = (cnt_ff >= CntBits'(MaxSegments));
   assign sts.next_hole = (CntBits'(in1) < cnt_ff) && (idx_ff + 1'b1 < cnt_ff)
                          && hole_ff[in1];
   assign sts.prev_hole = (idx_ff != '0) && hole_ff[ip];
   assign sts.k_done_up = (k_ff <= idx_ff + 1'b1);
   assign sts.k_done_dn = (k_ff + 1'b1 >= cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CntBits'(1);
         pid_ff <= 16'd1;
         hole_ff[0] <= 1'b1;
         base_ff[0] <= '0;
         len_ff[0] <= LenBits'(1) << AddrBits;
      end else begin
         if (cmd.init) begin
            cnt_ff <= CntBits'(1);
            pid_ff <= 16'd1;
            hole_ff[0] <= 1'b1;
            base_ff[0] <= '0;
            len_ff[0] <= msize_in;
         end
         if (cmd.cnt_inc) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.cnt_dec) cnt_ff <= cnt_ff - 1'b1;
         if (cmd.pid_inc) pid_ff <= pid_ff + 1'b1;
         if (cmd.shift_up) begin
            base_ff[kk] <= base_ff[kp];
            len_ff[kk]  <= len_ff[kp];
            own_ff[kk]  <= own_ff[kp];
            prio_ff[kk] <= prio_ff[kp];
            hole_ff[kk] <= hole_ff[kp];
         end
         if (cmd.shift_dn) begin
            base_ff[kk] <= base_ff[kn];
            len_ff[kk]  <= len_ff[kn];
            own_ff[kk]  <= own_ff[kn];
            prio_ff[kk] <= prio_ff[kn];
            hole_ff[kk] <= hole_ff[kn];
         end
         if (cmd.split) begin
            base_ff[in1] <= hb + size_ff[AddrBits-1:0];
            len_ff[in1]  <= hl - size_ff;
            own_ff[in1]  <= '0;
            prio_ff[in1] <= '0;
            hole_ff[in1] <= 1'b1;
         end
         if (cmd.split || cmd.alloc_exact) begin
            len_ff[ii]  <= size_ff;
            hole_ff[ii] <= 1'b0;
            own_ff[ii]  <= pid_ff;
            prio_ff[ii] <= gp_ff;
         end
         if (cmd.free_mark) begin
            hole_ff[ii] <= 1'b1;
            own_ff[ii]  <= '0;
            prio_ff[ii] <= '0;
         end
         if (cmd.merge_next) len_ff[ii] <= hl + len_ff[in1];
         if (cmd.merge_prev) len_ff[ip] <= len_ff[ip] + hl;
      end
   end

   // index, request and result registers
   always_ff @(posedge clock) begin
      if (cmd.scan_rst) idx_ff <= '0;
      else if (cmd.scan) idx_ff <= idx_ff + 1'b1;
      if (cmd.set_k_top) k_ff <= cnt_ff;
      else if (cmd.merge_next) k_ff <= idx_ff + 1'b1;
      else if (cmd.merge_prev) k_ff <= idx_ff;
      else if (cmd.shift_up) k_ff <= k_ff - 1'b1;
      else if (cmd.shift_dn) k_ff <= k_ff + 1'b1;
      if (cmd.merge_prev) idx_ff <= idx_ff - 1'b1;
      if (cmd.load) begin
         op_ff <= req_op;
         gp_ff <= gp_in;
         size_ff <= req_size;
         start_ff <= req_free_start;
      end
      if (cmd.res_set) begin
         rsp_status <= cmd.res_status;
         rsp_pid <= '0;
         rsp_seg_first <= '0;
         rsp_seg_last <= '0;
         rsp_granted_priority <= (op_ff == OP_ALLOC) ? gp_ff : 3'd0;
      end
      if (cmd.split || cmd.alloc_exact) begin
         rsp_status <= ST_ALLOC;
         rsp_pid <= pid_ff;
         rsp_seg_first <= hb;
         rsp_seg_last <= 16'(hb + size_ff[AddrBits-1:0] - 1'b1);
         rsp_granted_priority <= gp_ff;
      end
      if (cmd.free_mark) begin
         rsp_status <= ST_FREED;
         rsp_pid <= own_ff[ii];
         rsp_seg_first <= hb;
         rsp_seg_last <= 16'(LenBits'(hb) + hl - 1'b1);
         rsp_granted_priority <= prio_ff[ii];
      end
   end
endmodule

// ===== rtl/core/first_fit_segment_allocator_core.sv =====
// channel    ports                          moves
// req        req_valid / req_ready          one allocate or free request
// rsp        rsp_valid / rsp_ready          one result per request
// csr        csr_valid / csr_ready          memory size, reinitializes table
//
// flow: decode, then a table scan over the entries to the first hit; a split
// adds a shift-up over the entries moved up, then a fill step; a free adds a
// mark step, then a shift-down over moved entries for each merge; a zero
// size skips the scan; one-entry-a-cycle scan and shift loops set the time
// reset: synchronous, table holds one hole of 65536 words, next pid one
// stalls: a new request or csr write waits until the result has been taken
module first_fit_segment_allocator_core
   import ffsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic signed [7:0]   req_priority_req,
   input  logic [16:0]         req_size,
   input  logic [15:0]         req_free_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [15:0]         rsp_pid,
   output logic [15:0]         rsp_seg_first,
   output logic [15:0]         rsp_seg_last,
   output logic [2:0]          rsp_granted_priority,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [16:0]         csr_data
);
   ffsa_cmd_type cmd;
   ffsa_sts_type sts;

   // sequencer: scan, shift and merge steps
   ffsa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .csr_valid, .csr_ready,
      .rsp_valid, .rsp_ready, .sts, .cmd
   );

   // segment table and result registers
   ffsa_dp u_dp (
      .clock, .reset, .cmd, .sts, .csr_data, .req_op, .req_priority_req,
      .req_size, .req_free_start, .rsp_status, .rsp_pid, .rsp_seg_first,
      .rsp_seg_last, .rsp_granted_priority
   );
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import ffsa_pkg::*;

   // request fields as driven on the req channel
   typedef struct {
      logic        op;
      logic [7:0]  prio;
      logic [16:0] size;
      logic [15:0] start;
   } alloc_req_type;

   // one result as seen on the rsp channel
   typedef struct {
      logic [2:0]  status;
      logic [15:0] pid;
      logic [15:0] first;
      logic [15:0] last;
      logic [2:0]  prio;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_ALLOC;
   logic [7:0]  req_priority_req = '0;
   logic [16:0] req_size = '0;
   logic [15:0] req_free_start = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_pid;
   logic [15:0] rsp_seg_first;
   logic [15:0] rsp_seg_last;
   logic [2:0]  rsp_granted_priority;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data = '0;

   // predictor copy of the segment table
   logic [16:0] mem_words;
   logic [15:0] tbl_base [MaxSegments];
   logic [16:0] tbl_len  [MaxSegments];
   logic [15:0] tbl_owner[MaxSegments];
   logic [2:0]  tbl_prio [MaxSegments];
   logic        tbl_hole [MaxSegments];
   int          tbl_count;
   logic [15:0] pid_next;

   alloc_rsp_type expected_rsps[$];
   int            fail_count = 0;
   bit            stall_hold = 1'b0;

   always #5 clock = ~clock;

   first_fit_segment_allocator_core i_dut (.*);

   // ---------------- predictor ----------------
   function automatic void table_init();
      for (int n = 0; n < MaxSegments; n++) begin
         tbl_base[n] = '0;
         tbl_len[n] = '0;
         tbl_owner[n] = '0;
         tbl_prio[n] = '0;
         tbl_hole[n] = 1'b0;
      end
      tbl_len[0] = mem_words;
      tbl_hole[0] = 1'b1;
      tbl_count = 1;
      pid_next = 16'd1;
   endfunction

   function automatic void copy_slot(int dst, int src);
      tbl_base[dst] = tbl_base[src];
      tbl_len[dst] = tbl_len[src];
      tbl_owner[dst] = tbl_owner[src];
      tbl_prio[dst] = tbl_prio[src];
      tbl_hole[dst] = tbl_hole[src];
   endfunction

   function automatic void drop_slot(int idx);
      for (int n = idx; n + 1 < tbl_count; n++) copy_slot(n, n + 1);
      tbl_count--;
   endfunction

   function automatic alloc_rsp_type predict_segment(alloc_req_type r);
      alloc_rsp_type o;
      logic [2:0] p;
      int i;
      logic [15:0] first;
      o = '{ST_ALLOC, 16'd0, 16'd0, 16'd0, 3'd0};
      if (r.op == OP_ALLOC) begin
         if (r.prio[7]) p = 3'd0;
         else if (r.prio > MaxPriority) p = 3'(MaxPriority);
         else p = r.prio[2:0];
         o.prio = p;
         if (r.size == 0) begin
            o.status = ST_ZERO;
            return o;
         end
         for (i = 0; i < tbl_count; i++)
            if (tbl_hole[i] && tbl_len[i] >= r.size) break;
         if (i >= tbl_count) begin
            o.status = ST_NOFIT;
            return o;
         end
         first = tbl_base[i];
         if (tbl_len[i] > r.size) begin
            if (tbl_count >= MaxSegments) begin
               o.status = ST_FULL;
               return o;
            end
            for (int k = tbl_count; k > i + 1; k--) copy_slot(k, k - 1);
            tbl_base[i+1] = first + r.size[15:0];
            tbl_len[i+1] = tbl_len[i] - r.size;
            tbl_owner[i+1] = '0;
            tbl_prio[i+1] = '0;
            tbl_hole[i+1] = 1'b1;
            tbl_count++;
         end
         tbl_len[i] = r.size;
         tbl_hole[i] = 1'b0;
         tbl_owner[i] = pid_next;
         tbl_prio[i] = p;
         o.pid = pid_next;
         o.first = first;
         o.last = first + r.size[15:0] - 16'd1;
         pid_next = pid_next + 16'd1;
      end else begin
         for (i = 0; i < tbl_count; i++)
            if (!tbl_hole[i] && tbl_base[i] == r.start) break;
         if (i >= tbl_count) begin
            o.status = ST_NOSEG;
            return o;
         end
         o.status = ST_FREED;
         o.pid = tbl_owner[i];
         o.first = tbl_base[i];
         o.last = tbl_base[i] + tbl_len[i][15:0] - 16'd1;
         o.prio = tbl_prio[i];
         tbl_hole[i] = 1'b1;
         tbl_owner[i] = '0;
         tbl_prio[i] = '0;
         if (i + 1 < tbl_count && tbl_hole[i+1]) begin
            tbl_len[i] += tbl_len[i+1];
            drop_slot(i + 1);
         end
         if (i > 0 && tbl_hole[i-1]) begin
            tbl_len[i-1] += tbl_len[i];
            drop_slot(i);
         end
      end
      return o;
   endfunction

   // ---------------- driving ----------------
   // called at a falling edge; valid stays up after an accept until a
   // later call that waits first or release_request drops it
   task automatic send_request(alloc_req_type r);
      int w;
      w = $urandom_range(0, 10);
      if (w != 0) begin
         req_valid <= 1'b0;
         repeat (w) @(negedge clock);
      end
      req_op <= r.op;
      req_priority_req <= r.prio;
      req_size <= r.size;
      req_free_start <= r.start;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_segment(r));
      @(negedge clock);
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
   endtask

   task automatic do_alloc(int sz, int pr = 2);
      alloc_req_type r;
      r = '{OP_ALLOC, pr[7:0], sz[16:0], 16'($urandom)};
      send_request(r);
   endtask

   task automatic do_free(int st);
      alloc_req_type r;
      r = '{OP_FREE, 8'($urandom), 17'($urandom), st[15:0]};
      send_request(r);
   endtask

   // wait for the block to drain, then write the memory size
   task automatic write_mem_size(logic [16:0] v);
      release_request();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      mem_words = (v == 0) ? 17'd1 : (v > 17'h10000 ? 17'h10000 : v);
      table_init();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------- result checking ----------------
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result status %0d", rsp_status);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); fail_count++;
            end
            if (rsp_pid !== e.pid) begin
               $error("pid exp %0d got %0d", e.pid, rsp_pid); fail_count++;
            end
            if (rsp_seg_first !== e.first) begin
               $error("seg_first exp %0d got %0d", e.first, rsp_seg_first); fail_count++;
            end
            if (rsp_seg_last !== e.last) begin
               $error("seg_last exp %0d got %0d", e.last, rsp_seg_last); fail_count++;
            end
            if (rsp_granted_priority !== e.prio) begin
               $error("granted_priority exp %0d got %0d", e.prio, rsp_granted_priority);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls: random wait per result, plus a long hold when asked
   always begin : receiver
      int w;
      w = $urandom_range(0, 10);
      if (w != 0 || stall_hold) begin
         rsp_ready <= 1'b0;
         repeat (w) @(negedge clock);
         while (stall_hold) @(negedge clock);
      end
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!(rsp_valid && rsp_ready));
      @(negedge clock);
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      do_alloc(0, -128);                  // zero size, negative prio
      do_alloc(17'h10000, 127);           // whole memory, exact fit
      do_alloc(1, 4);                     // nothing fits
      do_free(0);                         // free whole
      do_free(0);                         // start is a hole
      do_free(16'hffff);                  // unknown start
      for (int n = 0; n < 5; n++) do_alloc(16, n);
      do_free(16);                        // middle, no merge
      do_free(48);                        // both neighbours owned, no merge
      do_free(32);                        // merge both sides
      do_alloc(16, 3);                    // refill first fit
      do_alloc(17'hffff, 1);              // no fit
      do_free(0);
      do_free(64);
   endtask

   task automatic test_full_table();
      write_mem_size(17'd20);
      for (int n = 0; n < 17; n++) do_alloc(1, n);  // last two splits hit full
      do_alloc(5, 0);                     // exact remaining hole
      do_alloc(1, 0);
      do_free(19);
      do_free(0);
   endtask

   task automatic test_random(int cnt, int maxsz);
      logic [15:0] owned[$];
      for (int n = 0; n < cnt; n++) begin
         int k;
         k = $urandom_range(0, 99);
         // track owned starts from the predictor table
         owned.delete();
         for (int j = 0; j < tbl_count; j++) if (!tbl_hole[j]) owned.push_back(tbl_base[j]);
         if (k < 45) do_alloc($urandom_range(1, maxsz), $signed(8'($urandom)));
         else if (k < 85 && owned.size() != 0) do_free(owned[$urandom_range(0, owned.size()-1)]);
         else if (k < 90) do_alloc($urandom_range(0, 17'h1ffff) & 17'h1ffff, $urandom);
         else if (k < 93) do_alloc(0, $urandom);
         else do_free($urandom);
      end
   endtask

   task automatic test_backpressure();
      stall_hold = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            stall_hold = 1'b0;
         end
         begin
            for (int n = 0; n < 4; n++) do_alloc($urandom_range(1, 8), n);
            release_request();
         end
      join
   endtask

   task automatic test_size_clamp();
      write_mem_size(17'd0);              // acts as one word
      do_alloc(1, 0);
      do_alloc(1, 0);
      do_free(0);
      write_mem_size(17'h1ffff);          // clamped to full space
   endtask

   initial begin
      mem_words = 17'h10000;
      table_init();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_backpressure();
      test_size_clamp();
      test_random(300, 8192);
      write_mem_size(17'd300);
      test_random(300, 40);
      write_mem_size(17'd64);
      test_random(200, 12);
      release_request();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench NOT OK");
      $finish;
   end
endmodule
